>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/sha_pkg.sv
// package with types, constants and round functions of the sha-256 hasher
package sha_pkg;

  localparam logic [1:0] ModeAbsorb = 2'd0;
  localparam logic [1:0] ModeAbsorbFinish = 2'd1;
  localparam logic [1:0] ModeFinish = 2'd2;
  localparam logic [1:0] ModeReserved = 2'd3;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = 2;

  // command passed from the front to the back
  typedef struct packed {
    logic       has_byte;
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

>>> hw/rtl/sha_front.sv
// front end: accepts words, classifies them and queues commands
module sha_front import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_mode_i,
  input  logic [7:0] in_byte_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  cmd_t                 fifo_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;
  logic                 push, pop;
  cmd_t                 cls;

  // mode 3 acts as a finish without a byte
  always_comb begin
    cls.data     = in_byte_i;
    cls.has_byte = (in_mode_i == ModeAbsorb) || (in_mode_i == ModeAbsorbFinish);
    cls.finish   = (in_mode_i != ModeAbsorb);
  end

  assign in_ready_o  = (count_q != QueuePtrW'(0) + (QueuePtrW+1)'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + {{QueuePtrW{1'b0}}, push} - {{QueuePtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> hw/rtl/sha_back.sv
// back end: block buffer, padding sequencer, round engine and digest output
module sha_back import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_index_o,
  output logic        out_last_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StAdd   = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];   // block buffer as big-endian words, then schedule window
  logic [5:0]  rnd_q;
  logic        fin_q;     // block being compressed belongs to a finish
  logic        mark_q;    // 0x80 byte already written
  logic        pad_len_q; // padding block carries the length
  logic [2:0]  oidx_q;
  logic        ovalid_q;
  logic [31:0] oword_q;

  logic [31:0] wt, t1, t2, wnew, e, a;
  logic        wr_en;
  logic [7:0]  wr_data;

  assign cmd_ready_o = (state_q == StIdle);
  assign e  = v_q[4];
  assign a  = v_q[0];
  assign wt = w_q[0];
  assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_q[5]) ^ (~e & v_q[6]))
            + RoundK[rnd_q] + wt;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];

  // next state, and the byte written at position fill_q: message byte or padding byte
  always_comb begin
    wr_en   = 1'b0;
    wr_data = cmd_i.data;
    state_d = state_q;
    fill_d  = fill_q;
    len_d   = len_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          if (cmd_i.has_byte) begin
            wr_en  = 1'b1;
            len_d  = len_q + 64'd8;
            fill_d = fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              state_d = StRound;
            end else if (cmd_i.finish) begin
              state_d = StPad;
            end
          end else begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        wr_en  = 1'b1;
        fill_d = fill_q + 6'd1;
        if (!mark_q) begin
          wr_data = 8'h80;
        end else if (pad_len_q && fill_q >= 6'd56) begin
          wr_data = len_q[{~fill_q[2:0], 3'b000} +: 8];
        end else begin
          wr_data = 8'h00;
        end
        if (fill_q == 6'd63) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        if (!fin_q) begin
          state_d = StIdle;
        end else if (!pad_len_q) begin
          state_d = StPad;
        end else begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_ready_i || !ovalid_q) begin
          if (ovalid_q && oidx_q == 3'd7) begin
            state_d = StIdle;
            len_d   = '0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // block buffer writes and round engine datapath
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_data;
    end else if (state_q == StRound) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wnew;
    end
    if (state_q != StRound && state_d == StRound) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (state_q == StRound) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      len_q     <= '0;
      rnd_q     <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      pad_len_q <= 1'b0;
      oidx_q    <= '0;
      ovalid_q  <= 1'b0;
      oword_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitHash[i];
      end
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      rnd_q   <= (state_q == StRound) ? rnd_q + 6'd1 : 6'd0;
      if (state_q == StIdle && cmd_valid_i) begin
        fin_q     <= cmd_i.finish;
        mark_q    <= 1'b0;
        pad_len_q <= 1'b0;
      end
      if (state_q == StPad && !mark_q) begin
        // the length fits behind the 0x80 byte only below position 56
        mark_q    <= 1'b1;
        pad_len_q <= (fill_q < 6'd56);
      end
      if (state_q == StAdd) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
        // long tail: the next block holds zeros and the length
        if (fin_q && mark_q) begin
          pad_len_q <= 1'b1;
        end
      end
      if (state_q == StOut) begin
        if (out_ready_i || !ovalid_q) begin
          if (ovalid_q && oidx_q == 3'd7) begin
            ovalid_q <= 1'b0;
            oidx_q   <= '0;
            fin_q    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
              h_q[i] <= InitHash[i];
            end
          end else begin
            ovalid_q <= 1'b1;
            oword_q  <= h_q[ovalid_q ? oidx_q + 3'd1 : oidx_q];
            oidx_q   <= ovalid_q ? oidx_q + 3'd1 : oidx_q;
          end
        end
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;
  assign out_index_o = oidx_q;
  assign out_last_o  = (oidx_q == 3'd7);

endmodule

>>> hw/rtl/sha256_byte_stream_hasher.sv
// top level of the byte-stream sha-256 hasher
// usage:
// - slave side s_axis_*: one message byte per word; tuser holds mode
//   (0 absorb, 1 absorb then finish, 2 or 3 finish without byte)
// - master side m_axis_*: after a finish, eight digest words, word 0 first;
//   tuser holds the word index, tlast marks the eighth word
// - a four-entry command queue sits between the front and the back, so
//   bytes are taken while the back compresses or a digest waits
// each full block runs the round loop and then the add step in the
//   single round unit, which takes no byte while it compresses
// a finish: padding sweep to the end of each padded block, one or two
//   compressions, then eight digest words from a single output register
// reset clears the queue, fill count and length, and loads the initial hash
// a stalled receiver holds the current digest word; the back waits and the
//   queue fills, after which s_axis_tready drops
`include "assert_macros.svh"
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word[31:0]
  output logic [2:0]  m_axis_tuser,   // word_index[2:0]
  output logic        m_axis_tlast
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  sha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_index_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  // the back never takes a command while a digest is streaming out
  `ASSERT_IMPLIES(a_no_cmd_during_out, clk_i, rst_ni, m_axis_tvalid, !cmd_ready)
  // after the last word is taken the output goes idle
  `ASSERT_IMPLIES(a_last_wraps, clk_i, rst_ni,
                  m_axis_tvalid && m_axis_tready && m_axis_tlast,
                  ##1 !m_axis_tvalid)

endmodule
